### hdl/vfgm_pkg.sv
// Package: shared types and constants for the voxel face greedy mesher.
`timescale 1ns / 1ps
package vfgm_pkg;
  localparam int unsigned SliceW = 8;
  localparam int unsigned SliceH = 8;
  localparam int unsigned SliceCells = SliceW * SliceH;
  localparam int unsigned UW = $clog2(SliceW);
  localparam int unsigned VW = $clog2(SliceH);
  localparam int unsigned AW = $clog2(SliceCells);
  localparam int unsigned MaxResults = 32;
  localparam int unsigned RCW = $clog2(MaxResults + 1);
  localparam logic [7:0] MaterialMask = 8'hFF;

  typedef struct packed {
    logic [15:0] cell_voxel;
    logic [15:0] neighbor_voxel;
    logic        cell_transparent;
    logic        cell_solid;
    logic        neighbor_transparent;
    logic        neighbor_solid;
  } cell_in_t;

  typedef struct packed {
    logic [2:0]  rect_u;
    logic [2:0]  rect_v;
    logic [3:0]  rect_width;
    logic [3:0]  rect_height;
    logic [15:0] rect_voxel;
    logic        no_faces;
    logic        last_rect;
  } rect_out_t;

  // Classified cell handed from front to back.
  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } mask_ent_t;
endpackage

### hdl/vfgm_front.sv
// Front end: face rule classification of each accepted cell.
`timescale 1ns / 1ps
module vfgm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  vfgm_pkg::cell_in_t   cell_i,
  input  logic                 collision_mode_i,
  output vfgm_pkg::mask_ent_t  ent_o
);
  import vfgm_pkg::*;
  logic [AW:0] count_q, count_d;
  logic [7:0]  cmat, nmat;
  logic        show;

  always_comb begin
    cmat = cell_i.cell_voxel[7:0] & MaterialMask;
    nmat = cell_i.neighbor_voxel[7:0] & MaterialMask;
    if (cmat == 8'd0) show = 1'b0;
    else if (collision_mode_i) show = cell_i.cell_solid & ~cell_i.neighbor_solid;
    else if (nmat == 8'd0) show = 1'b1;
    else if (cell_i.cell_transparent && cell_i.neighbor_transparent) show = nmat != cmat;
    else if (!cell_i.cell_transparent && !cell_i.neighbor_transparent) show = 1'b0;
    else show = 1'b1;
  end

  always_comb begin
    count_d = count_q;
    if (take_i) begin
      if (count_q == (AW+1)'(SliceCells - 1)) count_d = '0;
      else count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else count_q <= count_d;
  end

  assign ent_o.word = show ? cell_i.cell_voxel : 16'd0;
  assign ent_o.last = (count_q == (AW+1)'(SliceCells - 1));
endmodule

### hdl/vfgm_back.sv
// Back end: mask store, slice load and greedy rectangle merge.
`timescale 1ns / 1ps
module vfgm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ent_valid_i,
  input  vfgm_pkg::mask_ent_t  ent_i,
  output logic                 ent_ready_o,
  output logic                 res_valid_o,
  output vfgm_pkg::rect_out_t  res_o
);
  import vfgm_pkg::*;
  localparam logic [2:0] S_LOAD = 3'd0, S_SCAN = 3'd1, S_ROW = 3'd2,
                         S_GROW = 3'd3, S_CLR = 3'd4, S_FIN = 3'd5;

  logic [15:0]    mem_q [SliceCells];
  logic [15:0]    rd_q;
  logic [2:0]     st_q, st_d;
  logic [AW-1:0]  wa_q, wa_d;
  logic [UW-1:0]  u_q, u_d, k_q, k_d;
  logic [VW-1:0]  v_q, v_d, r_q, r_d;
  logic [UW:0]    w_q, w_d;
  logic [VW:0]    h_q, h_d;
  logic [15:0]    word_q, word_d;
  logic [RCW-1:0] n_q, n_d;
  logic           pend_q, pend_d;
  rect_out_t      pend_rect_q, pend_rect_d;
  logic           res_v_q, res_v_d;
  rect_out_t      res_q, res_d;
  logic [AW-1:0]  ra, mem_wa;
  logic [15:0]    mem_wd;
  logic           mem_we;

  assign ent_ready_o = (st_q == S_LOAD);
  assign res_valid_o = res_v_q;
  assign res_o = res_q;

  always_comb begin
    st_d = st_q; wa_d = wa_q; u_d = u_q; v_d = v_q; k_d = k_q; r_d = r_q;
    w_d = w_q; h_d = h_q; word_d = word_q; n_d = n_q;
    pend_d = pend_q; pend_rect_d = pend_rect_q;
    res_v_d = 1'b0; res_d = res_q;
    mem_we = 1'b0; mem_wa = wa_q; mem_wd = ent_i.word;
    unique case (st_q)
      S_LOAD: begin
        if (ent_valid_i) begin
          mem_we = 1'b1;
          wa_d = wa_q + 1'b1;
          if (ent_i.last) begin
            st_d = S_SCAN; wa_d = '0; u_d = '0; v_d = '0; n_d = '0; pend_d = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (rd_q != 16'd0) begin
          word_d = rd_q; w_d = (UW+1)'(1); h_d = (VW+1)'(1);
          st_d = S_ROW;
        end else if (u_q != UW'(SliceW - 1)) begin
          u_d = u_q + 1'b1;
        end else if (v_q != VW'(SliceH - 1)) begin
          u_d = '0; v_d = v_q + 1'b1;
        end else begin
          st_d = S_FIN;
        end
      end
      S_ROW: begin
        // widen along u while the next cell of the row matches
        if (({1'b0, u_q} + w_q < (UW+1)'(SliceW)) && (rd_q == word_q)) begin
          w_d = w_q + 1'b1;
        end else if (v_q == VW'(SliceH - 1)) begin
          st_d = S_CLR; k_d = '0; r_d = '0;
        end else begin
          st_d = S_GROW; k_d = '0;
        end
      end
      S_GROW: begin
        // compare the next row one cell per cycle
        if (rd_q != word_q) begin
          st_d = S_CLR; k_d = '0; r_d = '0;
        end else if ({1'b0, k_q} + 1'b1 == w_q) begin
          h_d = h_q + 1'b1; k_d = '0;
          if ({1'b0, v_q} + h_q + 1'b1 == (VW+1)'(SliceH)) begin
            st_d = S_CLR; r_d = '0;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_CLR: begin
        // zero the rectangle's cells, one per cycle
        mem_we = 1'b1;
        mem_wa = {v_q + r_q, u_q + k_q};
        mem_wd = 16'd0;
        if ({1'b0, k_q} + 1'b1 != w_q) begin
          k_d = k_q + 1'b1;
        end else if ({1'b0, r_q} + 1'b1 != h_q) begin
          k_d = '0; r_d = r_q + 1'b1;
        end else begin
          // show the rectangle held so far, hold this one
          res_v_d = pend_q;
          res_d = pend_rect_q;
          pend_d = 1'b1;
          pend_rect_d.rect_u = 3'(u_q);
          pend_rect_d.rect_v = 3'(v_q);
          pend_rect_d.rect_width = 4'(w_q);
          pend_rect_d.rect_height = 4'(h_q);
          pend_rect_d.rect_voxel = word_q;
          pend_rect_d.no_faces = 1'b0;
          pend_rect_d.last_rect = 1'b0;
          n_d = n_q + 1'b1;
          if (n_q == RCW'(MaxResults - 1)) begin
            st_d = S_FIN;
          end else if ({1'b0, u_q} + w_q != (UW+1)'(SliceW)) begin
            u_d = UW'({1'b0, u_q} + w_q); st_d = S_SCAN;
          end else if (v_q != VW'(SliceH - 1)) begin
            u_d = '0; v_d = v_q + 1'b1; st_d = S_SCAN;
          end else begin
            st_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        // held rectangle closes the slice, or the empty marker does
        res_v_d = 1'b1;
        if (pend_q) begin
          res_d = pend_rect_q;
        end else begin
          res_d = '0; res_d.no_faces = 1'b1;
        end
        res_d.last_rect = 1'b1;
        pend_d = 1'b0;
        st_d = S_LOAD;
      end
      default: st_d = S_LOAD;
    endcase
  end

  // read address follows the next state, so rd_q matches the current one
  always_comb begin
    unique case (st_d)
      S_ROW: ra = {v_d, UW'({1'b0, u_d} + w_d)};
      S_GROW: ra = {VW'({1'b0, v_d} + h_d), u_d + k_d};
      default: ra = {v_d, u_d};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; wa_q <= '0; u_q <= '0; v_q <= '0; k_q <= '0; r_q <= '0;
      w_q <= '0; h_q <= '0; word_q <= '0; n_q <= '0;
      pend_q <= 1'b0; pend_rect_q <= '0; res_v_q <= 1'b0; res_q <= '0;
    end else begin
      st_q <= st_d; wa_q <= wa_d; u_q <= u_d; v_q <= v_d; k_q <= k_d; r_q <= r_d;
      w_q <= w_d; h_q <= h_d; word_q <= word_d; n_q <= n_d;
      pend_q <= pend_d; pend_rect_q <= pend_rect_d; res_v_q <= res_v_d; res_q <= res_d;
    end
  end
endmodule

### hdl/vfgm_queue.sv
// Two-entry queue between classifier and merge engine.
`timescale 1ns / 1ps
module vfgm_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  vfgm_pkg::mask_ent_t  push_data_i,
  output logic                 full_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output vfgm_pkg::mask_ent_t  pop_data_o
);
  import vfgm_pkg::*;
  mask_ent_t  buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign pop_data_o = buf_q[rp_q];
  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= push_data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

### hdl/voxel_face_greedy_mesher_top.sv
// Top level: voxel face greedy mesher with command-style ports.
`timescale 1ns / 1ps
// One slice of 8x8 cells is fed in raster order, u fastest, one cell per
// transfer (start high while busy low). Cells are classified at once and
// queued; the merge engine writes them into its mask store one per cycle
// while the queue holds entries and no merge is running. After the 64th
// cell the merge walks the mask: it scans past empty cells, and per
// rectangle it widens along u cell by cell, compares the rows below one cell
// at a time and clears the rectangle's cells one by one; a closing step ends
// the slice. During the merge the first cell of the next slice can still be
// taken and waits in the queue; busy is then high until the merge is done.
// Results appear on res_valid_o for one cycle each and cannot be stalled;
// each rectangle is shown in the cycle after the next one is complete or the
// slice closes, so last_rect can be set on it. An empty slice gives a single
// marker with no_faces set. Write collision_mode only while the block is
// idle.
module voxel_face_greedy_mesher_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  vfgm_pkg::cell_in_t    cell_i,
  output logic                  res_valid_o,
  output vfgm_pkg::rect_out_t   res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i
);
  import vfgm_pkg::*;
  logic      mode_q, take, q_full, q_empty, pop, ready_b;
  mask_ent_t ent_f, ent_b;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (cfg_valid_i) mode_q <= cfg_data_i;
  end

  // busy while the queue is full or an entry waits while the back end is merging
  assign busy = q_full | (~ready_b & ~q_empty);
  assign take = start & ~busy;
  assign pop = ~q_empty & ready_b;

  vfgm_front u_front (.clk_i, .rst_ni, .take_i(take), .cell_i,
                      .collision_mode_i(mode_q), .ent_o(ent_f));
  vfgm_queue u_queue (.clk_i, .rst_ni, .push_i(take), .push_data_i(ent_f),
                      .full_o(q_full), .empty_o(q_empty), .pop_i(pop),
                      .pop_data_o(ent_b));
  vfgm_back u_back (.clk_i, .rst_ni, .ent_valid_i(~q_empty), .ent_i(ent_b),
                    .ent_ready_o(ready_b), .res_valid_o, .res_o);

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !take) else $error("push into full queue");
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.no_faces) |-> res_o.last_rect) else $error("marker not last");
  a_marker_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.no_faces) |-> (res_o.rect_width == 4'd0))
    else $error("marker has width");
endmodule

### tb/voxel_face_greedy_mesher_top_tb.sv
// Testbench: self-checking slice stimulus and greedy-mesh predictor for the mesher top.
`timescale 1ns / 1ps
module voxel_face_greedy_mesher_top_tb;
  import vfgm_pkg::*;

  localparam int unsigned NumItems = 460;
  localparam int unsigned NumDirCells = 5 * SliceCells;
  localparam int unsigned NumRandSlices =
    (NumItems - NumDirCells + SliceCells / 2) / SliceCells;
  localparam int unsigned TailCycles = 400;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  cell_in_t  cell_i = '0;
  logic      res_valid_o;
  rect_out_t res_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;

  voxel_face_greedy_mesher_top i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .cell_i,
    .res_valid_o,
    .res_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: own copy of the mask, fill level and face rule.
  logic [15:0] mask_words [SliceCells];
  int unsigned cells_loaded;
  logic        collide_mode;
  rect_out_t   rect_queue [$];
  int unsigned fail_count;
  bit          idle_enable;

  function automatic logic [AW-1:0] cell_idx(int unsigned u, int unsigned v);
    return AW'(u + v * SliceW);
  endfunction

  function automatic bit face_visible(cell_in_t c);
    logic [7:0] cm, nm;
    cm = c.cell_voxel[7:0] & MaterialMask;
    nm = c.neighbor_voxel[7:0] & MaterialMask;
    if (cm == 8'd0) return 1'b0;
    if (collide_mode) return c.cell_solid && !c.neighbor_solid;
    if (nm == 8'd0) return 1'b1;
    if (c.cell_transparent && c.neighbor_transparent) return nm != cm;
    if (!c.cell_transparent && !c.neighbor_transparent) return 1'b0;
    return 1'b1;
  endfunction

  // Greedy merge: widen along u, then grow along v while whole rows match.
  task automatic merge_mask();
    int unsigned n, u, w, h, k, du, dv;
    logic [15:0] word;
    bit grow;
    rect_out_t r;
    n = 0;
    for (int unsigned v = 0; v < SliceH && n < MaxResults; v++) begin
      u = 0;
      while (u < SliceW && n < MaxResults) begin
        word = mask_words[cell_idx(u, v)];
        if (word == 16'd0) begin
          u++;
        end else begin
          w = 1;
          while (u + w < SliceW && mask_words[cell_idx(u + w, v)] == word) w++;
          h = 1;
          grow = 1'b1;
          while (v + h < SliceH && grow) begin
            for (k = 0; k < w; k++)
              if (mask_words[cell_idx(u + k, v + h)] != word) grow = 1'b0;
            if (grow) h++;
          end
          r = '0;
          r.rect_u = u[2:0];
          r.rect_v = v[2:0];
          r.rect_width = w[3:0];
          r.rect_height = h[3:0];
          r.rect_voxel = word;
          rect_queue = {rect_queue, r};
          n++;
          for (dv = 0; dv < h; dv++)
            for (du = 0; du < w; du++)
              mask_words[cell_idx(u + du, v + dv)] = 16'd0;
          u += w;
        end
      end
    end
    if (n == 0) begin
      r = '0;
      r.no_faces = 1'b1;
      rect_queue = {rect_queue, r};
    end
    rect_queue[rect_queue.size() - 1].last_rect = 1'b1;
  endtask

  task automatic predict_cell(cell_in_t c);
    mask_words[AW'(cells_loaded)] = face_visible(c) ? c.cell_voxel : 16'd0;
    cells_loaded++;
    if (cells_loaded == SliceCells) begin
      merge_mask();
      cells_loaded = 0;
    end
  endtask

  // Check every result transfer against the oldest expected rectangle.
  always @(posedge clk_i) begin
    rect_out_t want;
    if (rst_ni && res_valid_o) begin
      if (rect_queue.size() == 0) begin
        $error("unexpected result: %p", res_o);
        fail_count++;
      end else begin
        want = rect_queue.pop_front();
        if (res_o.rect_u !== want.rect_u) begin
          $error("rect_u exp %0d got %0d", want.rect_u, res_o.rect_u); fail_count++;
        end
        if (res_o.rect_v !== want.rect_v) begin
          $error("rect_v exp %0d got %0d", want.rect_v, res_o.rect_v); fail_count++;
        end
        if (res_o.rect_width !== want.rect_width) begin
          $error("rect_width exp %0d got %0d", want.rect_width, res_o.rect_width);
          fail_count++;
        end
        if (res_o.rect_height !== want.rect_height) begin
          $error("rect_height exp %0d got %0d", want.rect_height, res_o.rect_height);
          fail_count++;
        end
        if (res_o.rect_voxel !== want.rect_voxel) begin
          $error("rect_voxel exp %h got %h", want.rect_voxel, res_o.rect_voxel);
          fail_count++;
        end
        if (res_o.no_faces !== want.no_faces) begin
          $error("no_faces exp %0b got %0b", want.no_faces, res_o.no_faces); fail_count++;
        end
        if (res_o.last_rect !== want.last_rect) begin
          $error("last_rect exp %0b got %0b", want.last_rect, res_o.last_rect);
          fail_count++;
        end
      end
    end
  end

  // Optional idle burst before a transfer, start dropped meanwhile.
  task automatic maybe_idle();
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // One cell transfer: hold start until sampled with busy low; start stays
  // high afterwards so that transfers can follow back to back.
  task automatic send_cell(cell_in_t c);
    bit accepted;
    maybe_idle();
    cell_i <= c;
    start <= 1'b1;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk_i);
      accepted = !busy;
      @(negedge clk_i);
    end
    predict_cell(c);
  endtask

  // Register write, only issued with the block idle.
  task automatic write_mode(logic mode);
    bit accepted;
    start <= 1'b0;
    wait (rect_queue.size() == 0);
    repeat (TailCycles) @(negedge clk_i);
    cfg_data_i <= mode;
    cfg_valid_i <= 1'b1;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk_i);
      accepted = cfg_ready_o;
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    collide_mode = mode;
  endtask

  function automatic cell_in_t rand_cell(int unsigned flavour);
    cell_in_t c;
    logic [7:0] mats [4] = '{8'h01, 8'h02, 8'hFF, 8'h80};
    c = '0;
    c.cell_transparent = 1'($urandom_range(0, 1));
    c.cell_solid = 1'($urandom_range(0, 1));
    c.neighbor_transparent = 1'($urandom_range(0, 1));
    c.neighbor_solid = 1'($urandom_range(0, 1));
    if (flavour == 0) begin
      c.cell_voxel = 16'($urandom_range(0, 16'hFFFF));
      c.neighbor_voxel = 16'($urandom_range(0, 16'hFFFF));
    end else begin
      // Few distinct words so that rectangles merge.
      c.cell_voxel = {$urandom_range(0, 1) ? 8'hFF : 8'h00, mats[2'($urandom_range(0, 3))]};
      c.neighbor_voxel = {8'h00, $urandom_range(0, 2) == 0 ? 8'h00
                                 : mats[2'($urandom_range(0, 3))]};
    end
    return c;
  endfunction

  typedef struct packed {
    logic [15:0] cv;
    logic [15:0] nv;
    logic [3:0]  flags;  // ct, cs, nt, ns
  } dir_row_t;

  // Directed rows: extremes and each branch of both face rules.
  localparam int unsigned NumDir = 12;
  dir_row_t dir_rows [NumDir] = '{
    '{16'h0000, 16'h0000, 4'b0000},  // air cell: never a face
    '{16'hFFFF, 16'h0000, 4'b0000},  // against air
    '{16'h0101, 16'h0202, 4'b1010},  // both transparent, different material
    '{16'h0101, 16'h0001, 4'b1010},  // both transparent, same material
    '{16'h0303, 16'h0404, 4'b0000},  // both opaque
    '{16'h0303, 16'h0404, 4'b1000},  // only cell transparent
    '{16'h0303, 16'h0404, 4'b0010},  // only neighbour transparent
    '{16'h8000, 16'hFFFF, 4'b1111},  // material zero with high byte set
    '{16'hFFFF, 16'hFFFF, 4'b1111},
    '{16'h00FF, 16'hFF00, 4'b0101},
    '{16'hAA55, 16'h55AA, 4'b0100},  // solid against non-solid
    '{16'h55AA, 16'hAA55, 4'b0001}
  };

  task automatic send_slice(int unsigned pattern);
    cell_in_t c;
    for (int unsigned i = 0; i < SliceCells; i++) begin
      case (pattern)
        0: c = '0;                                      // no faces at all
        1: begin                                        // one full-slice rectangle
          c = '0;
          c.cell_voxel = 16'hFFFF;
        end
        2: begin                                        // checkerboard: over 32 rects
          c = '0;
          c.cell_voxel = ((i + i / SliceW) % 2) ? 16'h0011 : 16'h0022;
        end
        default: c = rand_cell(1);
      endcase
      send_cell(c);
    end
  endtask

  initial begin
    cell_in_t c;
    fail_count = 0;
    cells_loaded = 0;
    collide_mode = 1'b0;
    idle_enable = 1'b1;
    foreach (mask_words[i]) mask_words[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes of whole slices, then the rule table in both modes.
    send_slice(0);
    send_slice(1);
    send_slice(2);
    for (int m = 0; m < 2; m++) begin
      write_mode(m[0]);
      for (int unsigned i = 0; i < SliceCells; i++) begin
        c = '0;
        c.cell_voxel = dir_rows[4'(i % NumDir)].cv;
        c.neighbor_voxel = dir_rows[4'(i % NumDir)].nv;
        {c.cell_transparent, c.cell_solid, c.neighbor_transparent, c.neighbor_solid}
          = dir_rows[4'(i % NumDir)].flags;
        send_cell(c);
      end
    end

    // Random slices; mode rewritten before every other slice, last slice with no idling.
    for (int unsigned s = 0; s < NumRandSlices; s++) begin
      if (s % 2 == 0) write_mode(1'($urandom_range(0, 1)));
      if (s == NumRandSlices - 1) idle_enable = 1'b0;
      for (int unsigned i = 0; i < SliceCells; i++)
        send_cell(rand_cell($urandom_range(0, 3) == 0 ? 0 : 1));
    end
    write_mode(1'b0);

    wait (rect_queue.size() == 0);
    repeat (TailCycles) @(negedge clk_i);
    if (fail_count == 0 && rect_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule

### files.f
hdl/vfgm_pkg.sv
hdl/vfgm_front.sv
hdl/vfgm_back.sv
hdl/vfgm_queue.sv
hdl/voxel_face_greedy_mesher_top.sv
tb/voxel_face_greedy_mesher_top_tb.sv
